/* rtl/ubds_pkg.sv */
// Shared constants and pipeline record types for the UART baud divisor search.
`timescale 1ns / 1ps
package ubds_pkg;

  localparam logic [7:0]  DIV_MIN     = 8'd4;
  localparam logic [7:0]  DIV_MAX     = 8'd254;
  localparam logic [31:0] CLK_RESET   = 32'd100000000;
  localparam logic [6:0]  PCT_RESET   = 7'd5;
  localparam logic [19:0] PPM_SCALE   = 20'd1000000;
  localparam logic [6:0]  PCT_SCALE   = 7'd100;
  localparam int          DIV_STAGES  = 32;
  localparam int          PPM_STAGES  = 20;

  typedef enum logic {
    REG_CLOCK   = 1'b0,
    REG_PERCENT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] baud;
    logic [7:0]  div;
    logic [31:0] gen;
    logic        ok;
    logic        first;
    logic        last;
  } cand_t;

  typedef struct packed {
    logic [23:0] baud;
    logic [29:0] gen;
    logic [7:0]  div;
    logic [31:0] act;
    logic [23:0] err;
    logic        found;
  } res_t;

endpackage

/* rtl/ubds_if.sv */
// Valid/ready channel interfaces for baud requests and divisor results.
`timescale 1ns / 1ps
interface ubds_req_if;
  logic        valid;
  logic        ready;
  logic [23:0] baud_rate;
  modport source (output valid, output baud_rate, input ready);
  modport sink (input valid, input baud_rate, output ready);
endinterface

interface ubds_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] requested_baud;
  logic [29:0] clock_divider;
  logic [7:0]  stage_divider;
  logic [31:0] actual_baud;
  logic [19:0] ppm_error;
  logic        fits_tolerance;
  modport source (output valid, output requested_baud, output clock_divider,
                  output stage_divider, output actual_baud, output ppm_error,
                  output fits_tolerance, input ready);
  modport sink (input valid, input requested_baud, input clock_divider,
                input stage_divider, input actual_baud, input ppm_error,
                input fits_tolerance, output ready);
endinterface

/* rtl/ubds_issue.sv */
// Candidate sequencer: steps the stage divider over its range for each request.
`timescale 1ns / 1ps
module ubds_issue
  import ubds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [31:0] ref_clock_hz,
  input  logic        req_valid,
  input  logic [23:0] req_baud,
  output logic        req_ready,
  output logic        cand_valid,
  output cand_t       cand,
  output logic [31:0] dividend,
  output logic [31:0] divisor
);

  logic        busy;
  logic [7:0]  div;
  logic [23:0] baud;
  logic [8:0]  mult;
  logic [32:0] prod;

  assign req_ready = en && (!busy || div == DIV_MAX);
  assign mult = {1'b0, div} + 9'd1;
  assign prod = baud * mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cand_valid <= 1'b0;
      div <= DIV_MIN;
    end else if (en) begin
      cand_valid <= busy;
      if (req_valid && req_ready) begin
        busy <= 1'b1;
        div <= DIV_MIN;
      end else if (busy) begin
        if (div == DIV_MAX) begin
          busy <= 1'b0;
        end else begin
          div <= div + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      baud <= req_baud;
    end
    if (en) begin
      cand.baud <= baud;
      cand.div <= div;
      cand.gen <= '0;
      cand.ok <= (ref_clock_hz != 32'd0) && (baud != 24'd0);
      cand.first <= (div == DIV_MIN);
      cand.last <= (div == DIV_MAX);
      dividend <= ref_clock_hz;
      divisor <= prod[31:0];
    end
  end

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (div >= DIV_MIN && div <= DIV_MAX))
    else $error("stage divider counter out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (busy && div == DIV_MIN))
    else $error("accepted request did not restart the sweep");

endmodule

/* rtl/ubds_div32.sv */
// Pipelined 32-bit restoring divider, one quotient bit per stage, with a candidate tag.
`timescale 1ns / 1ps
module ubds_div32
  import ubds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  cand_t       in_tag,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        out_valid,
  output cand_t       out_tag,
  output logic [31:0] quo
);

  logic [DIV_STAGES:0] v;
  cand_t               tag [0:DIV_STAGES];
  logic [31:0]         n   [0:DIV_STAGES];
  logic [31:0]         d   [0:DIV_STAGES];
  logic [31:0]         r   [0:DIV_STAGES];
  logic [31:0]         q   [0:DIV_STAGES];

  assign v[0] = in_valid;
  assign tag[0] = in_tag;
  assign n[0] = num;
  assign d[0] = den;
  assign r[0] = '0;
  assign q[0] = '0;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
      t = {r[k], n[k][DIV_STAGES-1-k]};
      diff = t - {1'b0, d[k]};
      ge = !diff[32];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k+1] <= tag[k];
        n[k+1] <= n[k];
        d[k+1] <= d[k];
        r[k+1] <= ge ? diff[31:0] : t[31:0];
        q[k+1] <= {q[k][30:0], ge};
      end
    end
  end

  assign out_valid = v[DIV_STAGES];
  assign out_tag = tag[DIV_STAGES];
  assign quo = q[DIV_STAGES];

endmodule

/* rtl/ubds_select.sv */
// Tracks the first strict error minimum over one request's candidates.
`timescale 1ns / 1ps
module ubds_select
  import ubds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  cand_t       in_tag,
  input  logic [31:0] act,
  output logic        res_valid,
  output res_t        res
);

  res_t        best;
  res_t        best_next;
  logic [31:0] err;
  logic        take;

  always_comb begin
    err = ({8'd0, in_tag.baud} > act) ? ({8'd0, in_tag.baud} - act)
                                       : (act - {8'd0, in_tag.baud});
    take = in_tag.ok && (in_tag.first || !best.found || err[23:0] < best.err);
    best_next = best;
    if (in_tag.first) begin
      best_next = '0;
      best_next.baud = in_tag.baud;
    end
    if (take) begin
      best_next.gen = in_tag.gen[29:0];
      best_next.div = in_tag.div;
      best_next.act = act;
      best_next.err = err[23:0];
      best_next.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= in_valid && in_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      best <= best_next;
      if (in_tag.last) begin
        res <= best_next;
      end
    end
  end

  a_err_below_baud: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.found) |-> (res.err < res.baud))
    else $error("chosen error not below requested baud");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.gen == '0 && res.err == '0))
    else $error("result without a usable pair carries nonzero fields");

endmodule

/* rtl/ubds_ppm.sv */
// Error-in-ppm divider pipeline and tolerance check; its last stage is the result register.
`timescale 1ns / 1ps
module ubds_ppm
  import ubds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [6:0]  max_error_percent,
  input  logic        res_valid,
  input  res_t        res,
  output logic        out_valid,
  output res_t        out_res,
  output logic [19:0] out_ppm,
  output logic        out_fits
);

  logic [PPM_STAGES:0] v;
  res_t                rr  [0:PPM_STAGES];
  logic                fit [0:PPM_STAGES];
  logic [43:0]         r   [0:PPM_STAGES];
  logic [19:0]         q   [0:PPM_STAGES];
  logic [30:0]         lhs;
  logic [30:0]         rhs;

  assign lhs = res.err * PCT_SCALE;
  assign rhs = res.baud * max_error_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr[0] <= res;
      fit[0] <= res.found && (lhs <= rhs);
      r[0] <= res.err * PPM_SCALE;
      q[0] <= '0;
    end
  end

  for (genvar k = 0; k < PPM_STAGES; k++) begin : g_stage
    logic [43:0] sh;
    logic [44:0] diff;

    always_comb begin
      sh = {20'd0, rr[k].baud} << (PPM_STAGES - 1 - k);
      diff = {1'b0, r[k]} - {1'b0, sh};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k+1] <= rr[k];
        fit[k+1] <= fit[k];
        r[k+1] <= diff[44] ? r[k] : diff[43:0];
        q[k+1] <= {q[k][18:0], !diff[44]};
      end
    end
  end

  assign out_valid = v[PPM_STAGES];
  assign out_res = rr[PPM_STAGES];
  assign out_ppm = rr[PPM_STAGES].found ? q[PPM_STAGES] : 20'd0;
  assign out_fits = fit[PPM_STAGES];

  a_fit_needs_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_fits) |-> out_res.found)
    else $error("tolerance flag set without a usable pair");

endmodule

/* rtl/uart_baud_divisor_search.sv */
// UART baud divisor search: top level with configuration registers and the full pipeline.
//
// A request on req carries a baud rate; one result per request leaves on rsp,
// in order, with the chosen generator and stage dividers, the baud rate they
// really give, the error in ppm and a tolerance flag. Both channels complete
// a transfer when valid and ready are high at a rising clock edge.
// Configuration goes through cfg_we, cfg_index and cfg_data: index 0 is the
// reference clock in hertz, index 1 the tolerance in percent; write only while
// no request is in flight.
// Each request is swept over 251 stage divider values, one per cycle while rsp
// does not stall, through two pipelined 32-bit dividers; a new request is taken
// as the last candidate of the previous one issues. Between acceptance and
// result lie the candidate sweep, two 32-stage dividers, the multiply and select
// registers and the 21 registers of the ppm divider.
// Reset (synchronous, rst high) empties the pipeline and loads a 100 MHz clock
// and a 5 percent tolerance. When rsp stalls, the whole pipeline holds and
// req.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module uart_baud_divisor_search
  import ubds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  ubds_req_if.sink    req,
  ubds_rsp_if.source  rsp
);

  logic [31:0] ref_clock_hz;
  logic [6:0]  max_error_percent;
  logic        en;

  logic        c_valid;
  cand_t       c_tag;
  logic [31:0] c_num;
  logic [31:0] c_den;

  logic        g_valid;
  cand_t       g_tag;
  logic [31:0] g_quo;

  logic        m_valid;
  cand_t       m_tag;
  cand_t       m_tag_next;
  logic [31:0] m_num;
  logic [31:0] m_den;
  logic [40:0] m_prod;

  logic        a_valid;
  cand_t       a_tag;
  logic [31:0] a_quo;

  logic        s_valid;
  res_t        s_res;

  res_t        o_res;
  logic [19:0] o_ppm;
  logic        o_fits;

  assign en = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz <= CLK_RESET;
      max_error_percent <= PCT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLOCK:   ref_clock_hz <= cfg_data;
        REG_PERCENT: max_error_percent <= cfg_data[6:0];
        default:     ;
      endcase
    end
  end

  ubds_issue u_issue (
    .clk, .rst, .en, .ref_clock_hz,
    .req_valid(req.valid), .req_baud(req.baud_rate), .req_ready(req.ready),
    .cand_valid(c_valid), .cand(c_tag), .dividend(c_num), .divisor(c_den)
  );

  ubds_div32 u_gen_div (
    .clk, .rst, .en, .in_valid(c_valid), .in_tag(c_tag), .num(c_num), .den(c_den),
    .out_valid(g_valid), .out_tag(g_tag), .quo(g_quo)
  );

  assign m_prod = g_quo * ({1'b0, g_tag.div} + 9'd1);

  always_comb begin
    m_tag_next = g_tag;
    m_tag_next.gen = g_quo;
    m_tag_next.ok = g_tag.ok && (g_quo != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tag <= m_tag_next;
      m_num <= ref_clock_hz;
      m_den <= m_prod[31:0];
    end
  end

  ubds_div32 u_act_div (
    .clk, .rst, .en, .in_valid(m_valid), .in_tag(m_tag), .num(m_num), .den(m_den),
    .out_valid(a_valid), .out_tag(a_tag), .quo(a_quo)
  );

  ubds_select u_select (
    .clk, .rst, .en, .in_valid(a_valid), .in_tag(a_tag), .act(a_quo),
    .res_valid(s_valid), .res(s_res)
  );

  ubds_ppm u_ppm (
    .clk, .rst, .en, .max_error_percent, .res_valid(s_valid), .res(s_res),
    .out_valid(rsp.valid), .out_res(o_res), .out_ppm(o_ppm), .out_fits(o_fits)
  );

  assign rsp.requested_baud = o_res.baud;
  assign rsp.clock_divider = o_res.gen;
  assign rsp.stage_divider = o_res.div;
  assign rsp.actual_baud = o_res.act;
  assign rsp.ppm_error = o_ppm;
  assign rsp.fits_tolerance = o_fits;

endmodule
